>>> sv/sfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

	localparam int SYM_W = 8;
	localparam int OCC_W = 9;
	localparam int CMD_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_COUNT = 2'd0,
		CMD_TAKE  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	// control strobes from the sequencer to the count table
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr_all;
	} tbl_ctl_t;

endpackage

`default_nettype wire

>>> sv/sfr_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sfr_cmd_if;
	logic                            valid;
	logic                            ready;
	logic [sfr_pkg::CMD_W-1:0]       cmd;
	logic [sfr_pkg::SYM_W-1:0]       symbol;

	modport source (output valid, output cmd, output symbol, input ready);
	modport sink (input valid, input cmd, input symbol, output ready);
endinterface

`default_nettype wire

>>> sv/sfr_rank_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sfr_rank_if;
	logic                            valid;
	logic                            ready;
	logic [sfr_pkg::SYM_W-1:0]       ranked_symbol;
	logic [sfr_pkg::OCC_W-1:0]       occurrences;
	logic                            found;
	logic                            last;

	modport source (output valid, output ranked_symbol, output occurrences,
		output found, output last, input ready);
	modport sink (input valid, input ranked_symbol, input occurrences,
		input found, input last, output ready);
endinterface

`default_nettype wire

>>> sv/sfr_table.sv
`timescale 1ns / 1ps
`default_nettype none

module sfr_table #(
	parameter int DEPTH = 256,
	parameter int CNT_W = 9,
	parameter int IDX_W = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire sfr_pkg::tbl_ctl_t    ctl,
	input  wire logic [IDX_W-1:0]     rd_addr,
	input  wire logic [IDX_W-1:0]     wr_addr,
	input  wire logic [CNT_W-1:0]     wr_data,
	output logic [CNT_W-1:0]          rd_data
);

	logic [CNT_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [CNT_W-1:0] mem_rd_q;
	logic             vld_rd_q;

	// entry valid bits stand in for a clear of the whole array
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ctl.clr_all) begin
			vld_q <= '0;
		end else if (ctl.wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			mem_rd_q <= mem[rd_addr];
			vld_rd_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = vld_rd_q ? mem_rd_q : '0;

endmodule

`default_nettype wire

>>> sv/symbol_frequency_ranker.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte histogram with ranked read-out. Counters live in a single-port-read
// table of ALPHABET_SIZE entries with per-entry valid bits, so reset and a
// clear transaction empty the whole table together. A count transaction
// reads the table, then does a saturating write-back; a count of a symbol
// outside the alphabet, clear and the unused command need no write-back. A
// take transaction scans the whole table through its one read port, and it
// also waits for any previous result to be taken. Only take produces a
// result; it is held in an output register.
module symbol_frequency_ranker #(
	parameter int ALPHABET_SIZE = 256,
	parameter int COUNT_MAX     = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	sfr_cmd_if.sink          cmd_ch,
	sfr_rank_if.source       rank_ch
);

	localparam int IDX_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
	localparam int CNT_W = $clog2(COUNT_MAX + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALPHABET_SIZE - 1);
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(COUNT_MAX);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CNT_WR,
		ST_SCAN,
		ST_SCAN_END,
		ST_FIN
	} state_t;

	state_t                     state_q;
	logic [IDX_W-1:0]           addr_q;
	logic [IDX_W-1:0]           idx_s1;
	logic                       vld_s1;
	logic [IDX_W-1:0]           best_idx_q;
	logic [CNT_W-1:0]           best_cnt_q;
	logic [1:0]                 nz_q;
	logic                       out_valid_q;
	logic [sfr_pkg::SYM_W-1:0]  out_sym_q;
	logic [sfr_pkg::OCC_W-1:0]  out_occ_q;
	logic                       out_found_q;
	logic                       out_last_q;

	sfr_pkg::tbl_ctl_t          tbl_ctl;
	logic [IDX_W-1:0]           tbl_rd_addr;
	logic [IDX_W-1:0]           tbl_wr_addr;
	logic [CNT_W-1:0]           tbl_wr_data;
	logic [CNT_W-1:0]           tbl_rd_data;

	logic                       accept;
	logic                       sym_in_range;
	logic                       out_free;
	logic                       best_found;

	assign cmd_ch.ready  = (state_q == ST_IDLE);
	assign accept        = cmd_ch.valid && cmd_ch.ready;
	assign sym_in_range  = ({1'b0, cmd_ch.symbol} < 9'(ALPHABET_SIZE));
	assign out_free      = !out_valid_q || rank_ch.ready;
	assign best_found    = (best_cnt_q != '0);

	always_comb begin
		tbl_ctl     = '0;
		tbl_rd_addr = addr_q;
		tbl_wr_addr = addr_q;
		tbl_wr_data = '0;
		case (state_q)
			ST_IDLE: begin
				tbl_rd_addr = cmd_ch.symbol[IDX_W-1:0];
				if (accept) begin
					tbl_ctl.rd_en   = (cmd_ch.cmd == sfr_pkg::CMD_COUNT) && sym_in_range;
					tbl_ctl.clr_all = (cmd_ch.cmd == sfr_pkg::CMD_CLEAR);
				end
			end
			ST_CNT_WR: begin
				tbl_ctl.wr_en = 1'b1;
				tbl_wr_data   = (tbl_rd_data == CNT_MAX) ? tbl_rd_data
					: tbl_rd_data + CNT_W'(1);
			end
			ST_SCAN: begin
				tbl_ctl.rd_en = 1'b1;
			end
			ST_FIN: begin
				// zero the picked counter once its result is registered
				tbl_wr_addr   = best_idx_q;
				tbl_ctl.wr_en = out_free && best_found;
			end
			default: begin
			end
		endcase
	end

	sfr_table #(
		.DEPTH (ALPHABET_SIZE),
		.CNT_W (CNT_W),
		.IDX_W (IDX_W)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (tbl_ctl),
		.rd_addr (tbl_rd_addr),
		.wr_addr (tbl_wr_addr),
		.wr_data (tbl_wr_data),
		.rd_data (tbl_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			addr_q      <= '0;
			idx_s1      <= '0;
			vld_s1      <= 1'b0;
			best_idx_q  <= '0;
			best_cnt_q  <= '0;
			nz_q        <= 2'd0;
			out_valid_q <= 1'b0;
			out_sym_q   <= '0;
			out_occ_q   <= '0;
			out_found_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rank_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			// compare stage, entries arrive in ascending order so ties keep the smaller
			if (vld_s1) begin
				if (tbl_rd_data > best_cnt_q) begin
					best_cnt_q <= tbl_rd_data;
					best_idx_q <= idx_s1;
				end
				if (tbl_rd_data != '0 && nz_q != 2'd2) begin
					nz_q <= nz_q + 2'd1;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && cmd_ch.cmd == sfr_pkg::CMD_TAKE) begin
						addr_q     <= '0;
						best_cnt_q <= '0;
						best_idx_q <= '0;
						nz_q       <= 2'd0;
						state_q    <= ST_SCAN;
					end else begin
						addr_q <= cmd_ch.symbol[IDX_W-1:0];
						if (accept && cmd_ch.cmd == sfr_pkg::CMD_COUNT && sym_in_range) begin
							state_q <= ST_CNT_WR;
						end
					end
				end
				ST_CNT_WR: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					idx_s1 <= addr_q;
					vld_s1 <= 1'b1;
					addr_q <= addr_q + IDX_W'(1);
					if (addr_q == LAST_IDX) begin
						state_q <= ST_SCAN_END;
					end
				end
				ST_SCAN_END: begin
					vld_s1  <= 1'b0;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_found_q <= best_found;
						out_sym_q   <= sfr_pkg::SYM_W'(best_idx_q);
						out_occ_q   <= sfr_pkg::OCC_W'(best_cnt_q);
						out_last_q  <= best_found && (nz_q == 2'd1);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rank_ch.valid         = out_valid_q;
	assign rank_ch.ranked_symbol = out_sym_q;
	assign rank_ch.occurrences   = out_occ_q;
	assign rank_ch.found         = out_found_q;
	assign rank_ch.last          = out_last_q;

	a_empty_take_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_found_q |-> out_occ_q == '0 && out_sym_q == '0 && !out_last_q)
		else $error("empty take result carries nonzero fields");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_ctl.wr_en |-> state_q == ST_CNT_WR || state_q == ST_FIN)
		else $error("table written outside write-back or finish");

	a_write_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_ctl.wr_en |-> tbl_wr_data <= CNT_MAX)
		else $error("counter written beyond its maximum");

	a_scan_end_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN_END |-> $past(state_q) == ST_SCAN && $past(addr_q) == LAST_IDX)
		else $error("scan ended before the last entry");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rank_ch.ready |=> out_valid_q && $stable(out_sym_q)
			&& $stable(out_occ_q))
		else $error("pending result overwritten");

endmodule

`default_nettype wire

>>> test/symbol_frequency_ranker_checker.sv
`timescale 1ns / 1ps

module symbol_frequency_ranker_checker #(
	parameter int ALPHABET_SIZE = 256,
	parameter int COUNT_MAX     = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	sfr_cmd_if        cmd_ch,
	sfr_rank_if       rank_ch,
	output int        fail_count,
	output int        outstanding
);

	typedef struct {
		logic [sfr_pkg::SYM_W-1:0] ranked_symbol;
		logic [sfr_pkg::OCC_W-1:0] occurrences;
		logic                      found;
		logic                      last;
	} ranking_t;

	int unsigned histogram [ALPHABET_SIZE];
	ranking_t    due_rankings [$];

	// highest nonzero counter, ties to the smaller symbol; -1 when all are empty
	function automatic int leading_symbol();
		int          pick;
		int unsigned best;
		pick = -1;
		best = 0;
		for (int i = 0; i < ALPHABET_SIZE; i++) begin
			if (histogram[i] > best) begin
				best = histogram[i];
				pick = i;
			end
		end
		return pick;
	endfunction

	function automatic void tally_transaction(logic [sfr_pkg::CMD_W-1:0] code,
		logic [sfr_pkg::SYM_W-1:0] sym);
		ranking_t r;
		int       pick;
		r = '{default: '0};
		case (code)
			sfr_pkg::CMD_COUNT: begin
				if (int'(sym) < ALPHABET_SIZE && histogram[sym] < COUNT_MAX)
					histogram[sym]++;
			end
			sfr_pkg::CMD_CLEAR: begin
				foreach (histogram[i])
					histogram[i] = 0;
			end
			sfr_pkg::CMD_TAKE: begin
				pick = leading_symbol();
				if (pick >= 0) begin
					r.ranked_symbol = pick[sfr_pkg::SYM_W-1:0];
					r.occurrences   = histogram[pick][sfr_pkg::OCC_W-1:0];
					r.found         = 1'b1;
					histogram[pick] = 0;
					r.last          = (leading_symbol() < 0);
				end
				due_rankings = {due_rankings, r};
			end
			default: ;
		endcase
	endfunction

	function automatic void compare_ranking(ranking_t want);
		if (rank_ch.ranked_symbol !== want.ranked_symbol) begin
			fail_count++;
			$error("ranked_symbol: expected %0d, got %0d", want.ranked_symbol,
				rank_ch.ranked_symbol);
		end
		if (rank_ch.occurrences !== want.occurrences) begin
			fail_count++;
			$error("occurrences: expected %0d, got %0d", want.occurrences,
				rank_ch.occurrences);
		end
		if (rank_ch.found !== want.found) begin
			fail_count++;
			$error("found: expected %0d, got %0d", want.found, rank_ch.found);
		end
		if (rank_ch.last !== want.last) begin
			fail_count++;
			$error("last: expected %0d, got %0d", want.last, rank_ch.last);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (histogram[i])
				histogram[i] = 0;
			due_rankings.delete();
			outstanding <= 0;
		end else begin
			// result first: a take accepted on this edge cannot have produced it
			if (rank_ch.valid && rank_ch.ready) begin
				if (due_rankings.size() == 0) begin
					fail_count++;
					$error("ranked result with no take waiting: symbol %0d, occurrences %0d",
						rank_ch.ranked_symbol, rank_ch.occurrences);
				end else begin
					compare_ranking(due_rankings.pop_front());
				end
			end
			if (cmd_ch.valid && cmd_ch.ready)
				tally_transaction(cmd_ch.cmd, cmd_ch.symbol);
			outstanding <= due_rankings.size();
		end
	end

endmodule

>>> test/symbol_frequency_ranker_tb.sv
`timescale 1ns / 1ps

module symbol_frequency_ranker_tb;

	localparam int ALPHABET_SIZE  = 256;
	localparam int COUNT_MAX      = 256;
	localparam int ITEM_TARGET    = 1250;
	localparam int WATCHDOG_LIMIT = 12000;
	localparam int LONG_HOLD      = 1500;

	localparam logic [sfr_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

	logic clk;
	logic arst_n;

	int tx_idle_pct;
	int rx_stall_pct;
	int hold_requests;
	int sent;
	int quiet_cycles;
	int fail_count;
	int outstanding;

	sfr_cmd_if  cmd_ch ();
	sfr_rank_if rank_ch ();

	symbol_frequency_ranker #(
		.ALPHABET_SIZE(ALPHABET_SIZE),
		.COUNT_MAX    (COUNT_MAX)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd_ch),
		.rank_ch(rank_ch)
	);

	symbol_frequency_ranker_checker #(
		.ALPHABET_SIZE(ALPHABET_SIZE),
		.COUNT_MAX    (COUNT_MAX)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_ch     (cmd_ch),
		.rank_ch    (rank_ch),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver: random stalls, or a long hold-off when one is requested
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		rank_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				rank_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				rank_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (rank_ch.valid && rank_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("** symbol_frequency_ranker: FAILED **");
		$finish;
	end

	task automatic offer(logic [sfr_pkg::CMD_W-1:0] code, logic [sfr_pkg::SYM_W-1:0] sym);
		while ($urandom_range(99) < tx_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid  <= 1'b1;
		cmd_ch.cmd    <= code;
		cmd_ch.symbol <= sym;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		if (code != CMD_UNUSED)
			sent++;
	endtask

	// sender stays quiet until every ranked result has come back
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		@(posedge clk);
	endtask

	task automatic set_idling(int tx_pct, int rx_pct);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
	endtask

	// counts over a small pool with skewed picks, then takes at least one per pool slot
	task automatic ranked_batch();
		logic [sfr_pkg::SYM_W-1:0] pool [6];
		int                        width;
		int                        n;
		width = $urandom_range(1, 6);
		for (int k = 0; k < width; k++)
			pool[k] = sfr_pkg::SYM_W'($urandom_range(255));
		n = $urandom_range(width, 30);
		for (int k = 0; k < n; k++) begin
			offer(sfr_pkg::CMD_COUNT, pool[$urandom_range(0, $urandom_range(0, width - 1))]);
			if ($urandom_range(19) == 0)
				offer(CMD_UNUSED, sfr_pkg::SYM_W'($urandom_range(255)));
		end
		if ($urandom_range(9) == 0)
			offer(sfr_pkg::CMD_CLEAR, sfr_pkg::SYM_W'($urandom_range(255)));
		repeat (width + $urandom_range(0, 1))
			offer(sfr_pkg::CMD_TAKE, sfr_pkg::SYM_W'($urandom_range(255)));
	endtask

	initial begin
		logic [sfr_pkg::SYM_W-1:0] sym_a;
		logic [sfr_pkg::SYM_W-1:0] sym_b;
		int                        rnd_start;
		int                        phase;

		arst_n        <= 1'b0;
		cmd_ch.valid  <= 1'b0;
		cmd_ch.cmd    <= sfr_pkg::CMD_COUNT;
		cmd_ch.symbol <= '0;
		hold_requests = 0;
		sent          = 0;
		set_idling(0, 0);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: empty table, field extremes, ignored command, ties, clear
		offer(sfr_pkg::CMD_TAKE, 8'h00);
		offer(sfr_pkg::CMD_COUNT, 8'h00);
		offer(sfr_pkg::CMD_COUNT, 8'hff);
		offer(sfr_pkg::CMD_COUNT, 8'hff);
		offer(CMD_UNUSED, 8'haa);
		offer(sfr_pkg::CMD_TAKE, 8'hff);
		offer(sfr_pkg::CMD_TAKE, 8'h00);
		offer(sfr_pkg::CMD_TAKE, 8'h00);
		offer(sfr_pkg::CMD_COUNT, 8'h07);
		offer(sfr_pkg::CMD_COUNT, 8'h03);
		offer(sfr_pkg::CMD_COUNT, 8'h07);
		offer(sfr_pkg::CMD_COUNT, 8'h03);
		offer(sfr_pkg::CMD_TAKE, 8'h00);
		offer(sfr_pkg::CMD_COUNT, 8'h80);
		offer(sfr_pkg::CMD_CLEAR, 8'h00);
		offer(sfr_pkg::CMD_TAKE, 8'h00);
		offer(sfr_pkg::CMD_COUNT, 8'h55);
		offer(sfr_pkg::CMD_COUNT, 8'haa);
		offer(sfr_pkg::CMD_COUNT, 8'haa);
		offer(sfr_pkg::CMD_TAKE, 8'h55);
		offer(sfr_pkg::CMD_TAKE, 8'haa);
		offer(sfr_pkg::CMD_TAKE, 8'h00);
		drain();

		// saturation: two symbols pushed past the limit tie at the maximum
		set_idling(34, 34);
		sym_a = sfr_pkg::SYM_W'($urandom_range(255));
		sym_b = sym_a ^ (8'd1 << $urandom_range(7));
		for (int k = 0; k < COUNT_MAX + 1; k++) begin
			offer(sfr_pkg::CMD_COUNT, sym_a);
			offer(sfr_pkg::CMD_COUNT, sym_b);
		end
		repeat (3)
			offer(sfr_pkg::CMD_TAKE, sfr_pkg::SYM_W'($urandom_range(255)));

		// receiver holds off while takes keep arriving, so the input backs up
		set_idling(0, 0);
		drain();
		@(posedge clk);
		hold_requests++;
		for (int k = 0; k < 6; k++) begin
			offer(sfr_pkg::CMD_COUNT, sfr_pkg::SYM_W'($urandom_range(255)));
			offer(sfr_pkg::CMD_COUNT, sfr_pkg::SYM_W'($urandom_range(255)));
			offer(sfr_pkg::CMD_TAKE, sfr_pkg::SYM_W'($urandom_range(255)));
		end
		drain();

		rnd_start = sent;
		while (sent < ITEM_TARGET) begin
			phase = (sent - rnd_start) * 4 / (ITEM_TARGET - rnd_start);
			case (phase)
				0:       set_idling(0, 0);
				1:       set_idling(71, 0);
				2:       set_idling(0, 71);
				default: set_idling(34, 34);
			endcase
			if ($urandom_range(99) < 70) begin
				ranked_batch();
			end else begin
				repeat ($urandom_range(1, 8))
					offer(sfr_pkg::CMD_W'($urandom_range(3)),
						sfr_pkg::SYM_W'($urandom_range(255)));
			end
		end

		drain();
		repeat (ALPHABET_SIZE + 16) @(posedge clk);
		if (fail_count == 0)
			$display("** symbol_frequency_ranker: PASSED **");
		else
			$display("** symbol_frequency_ranker: FAILED **");
		$finish;
	end

endmodule
